### design/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared constants of the frequent peak tracker: width and reset value of the
// replacement threshold register.
// ----------------------------------------------------------------------------
`default_nettype none

package fpt_pkg;

    // replacement threshold register
    localparam int unsigned THRESHOLD_BITS = 8;
    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 8'd10;

    // threshold word type
    typedef logic [THRESHOLD_BITS-1:0] threshold_t;

endpackage

`default_nettype wire

### design/fpt_sample_if.sv
// ----------------------------------------------------------------------------
// fpt_sample_if
// Input channel of the frequent peak tracker: peak pixel index and window
// start flag under a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpt_sample_if #(
    parameter int unsigned KEY_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] peak_index;
    logic                window_start;

    modport source (
        output valid,
        output peak_index,
        output window_start,
        input  ready
    );

    modport sink (
        input  valid,
        input  peak_index,
        input  window_start,
        output ready
    );
endinterface

`default_nettype wire

### design/fpt_result_if.sv
// ----------------------------------------------------------------------------
// fpt_result_if
// Result channel of the frequent peak tracker: dominant pixel index under a
// valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface fpt_result_if #(
    parameter int unsigned KEY_BITS = 12
);
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] dominant_index;

    modport source (
        output valid,
        output dominant_index,
        input  ready
    );

    modport sink (
        input  valid,
        input  dominant_index,
        output ready
    );
endinterface

`default_nettype wire

### design/frequent_peak_tracker_core.sv
// ----------------------------------------------------------------------------
// frequent_peak_tracker_core
// Heavy-hitter tracker over frame peak positions. SLOT_COUNT slots each hold a
// key and a saturating hit count (key 0 marks an empty slot). Every input word
// is counted in the first slot matching its index or the first empty slot;
// the result word is the key of the first slot with the highest count, taken
// before a replacement. An index that finds no slot replaces the slot with
// the smallest count below the threshold register (slot 0 if none) with count 1.
// A set window_start flag clears all slots before its word is handled.
// Throughput is one word per cycle while the result sink does not stall. An
// accepted word waits in the input register until the result register is
// empty or being read; then one combinational pass over all slots (match
// search, count update, max and min scans) updates the slots and loads the
// result register. A new word can enter the input register while a result
// waits, as long as the input register is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module frequent_peak_tracker_core #(
    parameter int unsigned SLOT_COUNT = 5,
    parameter int unsigned KEY_BITS   = 12,
    parameter int unsigned COUNT_BITS = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire fpt_pkg::threshold_t cfg_wr_data,
    fpt_sample_if.sink              sample,
    fpt_result_if.source            result
);

    localparam int unsigned IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned LOW_BITS = (COUNT_BITS > fpt_pkg::THRESHOLD_BITS)
                                     ? COUNT_BITS : fpt_pkg::THRESHOLD_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // registers
    fpt_pkg::threshold_t   threshold_reg;
    logic                  in_valid_reg;
    logic [KEY_BITS-1:0]   in_key_reg;
    logic                  in_start_reg;
    logic                  out_valid_reg;
    logic [KEY_BITS-1:0]   out_key_reg;
    logic [KEY_BITS-1:0]   slot_key_reg   [SLOT_COUNT];
    logic [COUNT_BITS-1:0] slot_count_reg [SLOT_COUNT];

    // combinational pass
    logic                  fire;
    logic [KEY_BITS-1:0]   clr_key   [SLOT_COUNT];
    logic [COUNT_BITS-1:0] clr_count [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] hit_vec;
    logic [SLOT_COUNT-1:0] hit_sel;
    logic                  taken;
    logic [COUNT_BITS-1:0] upd_count [SLOT_COUNT];
    logic [COUNT_BITS-1:0] best_count;
    logic [KEY_BITS-1:0]   best_key;
    logic [LOW_BITS-1:0]   low_count;
    logic [IDX_BITS-1:0]   low_slot;
    logic [KEY_BITS-1:0]   slot_key_next   [SLOT_COUNT];
    logic [COUNT_BITS-1:0] slot_count_next [SLOT_COUNT];

    // handshake
    assign fire         = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || fire;
    assign result.valid          = out_valid_reg;
    assign result.dominant_index = out_key_reg;

    // window clear and slot match
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            clr_key[i]   = in_start_reg ? '0 : slot_key_reg[i];
            clr_count[i] = in_start_reg ? '0 : slot_count_reg[i];
            hit_vec[i]   = (clr_key[i] == in_key_reg) || (clr_key[i] == '0);
        end
    end

    // first matching or empty slot
    always_comb
    begin
        logic found;
        found   = 1'b0;
        hit_sel = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (hit_vec[i] && !found)
            begin
                hit_sel[i] = 1'b1;
                found      = 1'b1;
            end
        end
    end

    assign taken = |hit_vec;

    // saturating count update
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (hit_sel[i] && (clr_count[i] != COUNT_MAX))
                upd_count[i] = clr_count[i] + COUNT_BITS'(1);
            else
                upd_count[i] = clr_count[i];
        end
    end

    // first slot with highest count, smallest count below threshold
    // the slot that took the hit already carries the new key
    always_comb
    begin
        best_count = '0;
        best_key   = '0;
        low_count  = LOW_BITS'(threshold_reg);
        low_slot   = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (LOW_BITS'(upd_count[i]) < low_count)
            begin
                low_count = LOW_BITS'(upd_count[i]);
                low_slot  = IDX_BITS'(i);
            end
            if (upd_count[i] > best_count)
            begin
                best_count = upd_count[i];
                best_key   = hit_sel[i] ? in_key_reg : clr_key[i];
            end
        end
    end

    // next slot contents, with replacement when no slot took the index
    always_comb
    begin
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_key_next[i]   = hit_sel[i] ? in_key_reg : clr_key[i];
            slot_count_next[i] = upd_count[i];
            if (!taken && (low_slot == IDX_BITS'(i)))
            begin
                slot_key_next[i]   = in_key_reg;
                slot_count_next[i] = COUNT_BITS'(1);
            end
        end
    end

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= fpt_pkg::THRESHOLD_RESET;
        else if (cfg_wr_en)
            threshold_reg <= cfg_wr_data;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (sample.ready)
            in_valid_reg <= sample.valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_key_reg   <= sample.peak_index;
            in_start_reg <= sample.window_start;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_key_reg <= best_key;
    end

    // slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_key_reg[i]   <= '0;
                slot_count_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_key_reg[i]   <= slot_key_next[i];
                slot_count_reg[i] <= slot_count_next[i];
            end
        end
    end

endmodule

`default_nettype wire

### dv/fpt_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_tracker_checker
// Watches the sample and result channels and the threshold write port of the
// frequent peak tracker. It keeps its own copy of the slot table, predicts the
// dominant index for every accepted sample word, and compares each accepted
// result word with the oldest prediction.
// ----------------------------------------------------------------------------

module fpt_tracker_checker #(
    parameter int unsigned SLOT_COUNT = 5,
    parameter int unsigned KEY_BITS   = 12,
    parameter int unsigned COUNT_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  fpt_pkg::threshold_t cfg_wr_data,
    fpt_sample_if               sample,
    fpt_result_if               result,
    output int                  fail_count,
    output int                  words_pending
);

    // shadow slot table and threshold
    logic [KEY_BITS-1:0]   slot_key  [SLOT_COUNT];
    logic [COUNT_BITS-1:0] slot_hits [SLOT_COUNT];
    fpt_pkg::threshold_t   threshold;

    // dominant indexes still to come out, oldest first
    logic [KEY_BITS-1:0]   dominant_q [$];
    logic [KEY_BITS-1:0]   want_index;

    // count one peak, return the dominant key before any replacement
    function automatic logic [KEY_BITS-1:0] track_peak(input logic [KEY_BITS-1:0] key,
                                                       input logic ws);
        logic                  taken;
        logic [COUNT_BITS-1:0] best;
        logic [KEY_BITS-1:0]   best_key;
        int unsigned           low;
        int                    victim;
        taken    = 1'b0;
        best     = '0;
        best_key = '0;
        low      = 32'(threshold);
        victim   = 0;
        if (ws)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_key[i]  = '0;
                slot_hits[i] = '0;
            end
        end
        // first matching or empty slot takes the hit
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (!taken && (slot_key[i] == key || slot_key[i] == '0))
            begin
                slot_key[i] = key;
                if (slot_hits[i] != '1)
                    slot_hits[i] = slot_hits[i] + 1'b1;
                taken = 1'b1;
            end
        end
        // smallest count below threshold and first highest count
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (32'(slot_hits[i]) < low)
            begin
                low    = 32'(slot_hits[i]);
                victim = i;
            end
            if (slot_hits[i] > best)
            begin
                best     = slot_hits[i];
                best_key = slot_key[i];
            end
        end
        if (!taken)
        begin
            slot_key[victim]  = key;
            slot_hits[victim] = COUNT_BITS'(1);
        end
        return best_key;
    endfunction

    // predict on sample words, compare on result words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_key[i]  = '0;
                slot_hits[i] = '0;
            end
            threshold = fpt_pkg::THRESHOLD_RESET;
            dominant_q.delete();
            fail_count    <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                threshold = cfg_wr_data;
            if (result.valid && result.ready)
            begin
                if (dominant_q.size() == 0)
                begin
                    $error("unexpected result word, dominant_index %0d", result.dominant_index);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want_index = dominant_q.pop_front();
                    if (result.dominant_index !== want_index)
                    begin
                        $error("dominant_index mismatch: expected %0d, actual %0d",
                               want_index, result.dominant_index);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (sample.valid && sample.ready)
                dominant_q.push_back(track_peak(sample.peak_index, sample.window_start));
            words_pending <= dominant_q.size();
        end
    end

endmodule

### dv/tb_frequent_peak_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frequent_peak_tracker_core
// Drives the frequent peak tracker with directed peak sequences (empty key,
// full table, replacement ties, threshold extremes) and then random windows
// of recurring peaks plus a long saturating run, under random source and sink
// stalls. Prediction and comparison live in fpt_tracker_checker.
// ----------------------------------------------------------------------------

module tb_frequent_peak_tracker_core;

    localparam int          KEY_BITS   = 12;
    localparam time         CLK_PERIOD = 20ns;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    fpt_pkg::threshold_t cfg_wr_data;
    int                  fail_count;
    int                  words_pending;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    fpt_sample_if #(.KEY_BITS(KEY_BITS)) sample_ch ();
    fpt_result_if #(.KEY_BITS(KEY_BITS)) result_ch ();

    frequent_peak_tracker_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample_ch),
        .result      (result_ch)
    );

    fpt_tracker_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .sample        (sample_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // result sink with random stalls
    always @(posedge clk)
    begin
        result_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // run limit
    initial
    begin
        #(200_000 * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one sample word, with random idle cycles in front
    task automatic send_peak(input logic [KEY_BITS-1:0] key, input logic ws);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.peak_index   <= key;
        sample_ch.window_start <= ws;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
    endtask

    // wait until the tracker is drained, then write the threshold
    task automatic write_threshold(input fpt_pkg::threshold_t value);
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // windows of recurring peaks drawn from a small key pool, plus noise
    task automatic run_windows(input int n_items);
        logic [KEY_BITS-1:0] pool [8];
        logic [KEY_BITS-1:0] key;
        logic                ws;
        int                  pool_n;
        int                  win_left;
        int                  r;
        win_left = 0;
        pool_n   = 2;
        for (int n = 0; n < n_items; n++)
        begin
            ws = 1'b0;
            if (win_left == 0)
            begin
                win_left = $urandom_range(40, 4);
                pool_n   = $urandom_range(8, 2);
                for (int i = 0; i < 8; i++)
                    pool[i] = ($urandom_range(9) == 0) ? '0 : KEY_BITS'($urandom);
                ws = ($urandom_range(9) != 0);
            end
            r = $urandom_range(99);
            if (r < 10)
                key = KEY_BITS'($urandom);
            else if (r < 50)
                key = pool[0];
            else
                key = pool[$urandom_range(pool_n - 1)];
            // stray window start in the middle of a window
            if ($urandom_range(99) == 0)
                ws = 1'b1;
            send_peak(key, ws);
            win_left--;
        end
    endtask

    // one key hit long enough to saturate its count
    task automatic run_saturation(input int n_items);
        logic [KEY_BITS-1:0] hot_key;
        hot_key = KEY_BITS'($urandom_range(4095, 1));
        send_peak(hot_key, 1'b1);
        for (int n = 1; n < n_items; n++)
        begin
            if ($urandom_range(99) < 5)
                send_peak(KEY_BITS'($urandom), 1'b0);
            else
                send_peak(hot_key, 1'b0);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        cfg_wr_en              = 1'b0;
        cfg_wr_data            = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.peak_index   = '0;
        sample_ch.window_start = 1'b0;
        result_ch.ready        = 1'b0;
        send_idle_pct          = 10;
        recv_idle_pct          = 61;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // index zero lands in the empty slot, then a real key claims it
        send_peak(12'd0, 1'b1);
        send_peak(12'd0, 1'b0);
        send_peak(12'd4095, 1'b0);
        // fill the table, then force replacements with count ties
        send_peak(12'd1, 1'b0);
        send_peak(12'd2, 1'b0);
        send_peak(12'd3, 1'b0);
        send_peak(12'd4, 1'b0);
        send_peak(12'd5, 1'b0);
        send_peak(12'd4, 1'b0);
        send_peak(12'd6, 1'b0);
        send_peak(12'd2730, 1'b0);
        send_peak(12'd1365, 1'b0);
        // window start clears everything
        send_peak(12'd2048, 1'b1);
        send_peak(12'd2048, 1'b0);
        send_peak(12'd1024, 1'b0);

        // no slot below threshold: slot 0 goes
        write_threshold(8'd1);
        send_peak(12'd7, 1'b1);
        send_peak(12'd8, 1'b0);
        send_peak(12'd9, 1'b0);
        send_peak(12'd10, 1'b0);
        send_peak(12'd11, 1'b0);
        send_peak(12'd12, 1'b0);
        write_threshold(8'd0);
        send_peak(12'd13, 1'b0);
        send_peak(12'd8, 1'b0);
        write_threshold(8'd255);
        send_peak(12'd14, 1'b0);
        send_peak(12'd15, 1'b0);

        // sender lightly idle, receiver mostly stalled
        write_threshold(8'($urandom_range(20, 2)));
        run_saturation(300);
        run_windows(400);

        // sender mostly idle, receiver lightly stalled
        send_idle_pct = 61;
        recv_idle_pct = 10;
        write_threshold(8'($urandom_range(255, 1)));
        run_windows(400);

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_threshold(fpt_pkg::THRESHOLD_RESET);
        run_windows(400);

        // drain
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
design/fpt_pkg.sv
design/fpt_sample_if.sv
design/fpt_result_if.sv
design/frequent_peak_tracker_core.sv
dv/fpt_tracker_checker.sv
dv/tb_frequent_peak_tracker_core.sv
